/* rtl/ctc_greedy_decoder_core_assert.svh */
// Assertion macros for the greedy CTC decoder.
`ifndef CTC_GREEDY_DECODER_CORE_ASSERT_SVH
`define CTC_GREEDY_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CTCGD_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("ctcgd check failed");

// Next-cycle implication, checked outside reset.
`define CTCGD_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("ctcgd check failed");

`endif

/* rtl/ctcgd_pkg.sv */
// Types and constants shared by the greedy CTC decoder files.
package ctcgd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_CLASSES_DEF = 8192;
  localparam int MAX_STEPS_DEF   = 256;

  // Field and register widths
  localparam int SCORE_W      = 16;
  localparam int CHAR_INDEX_W = 13;
  localparam int CHAR_COUNT_W = 9;
  localparam int CLASS_CNT_W  = 14;
  localparam int DICT_W       = 13;
  localparam int CFG_DATA_W   = 14;
  localparam int CFG_INDEX_W  = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CLASSES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DICT_SIZE   = 1'b1;

  // Register reset values
  localparam logic [CLASS_CNT_W-1:0] NUM_CLASSES_RST = 14'd8192;
  localparam logic [DICT_W-1:0]      DICT_SIZE_RST   = 13'd8190;

  // Result kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      seq_end;
  } score_item_t;

  typedef struct packed {
    logic                      kind;
    logic [CHAR_INDEX_W-1:0]   char_idx;
    logic                      is_space;
    logic signed [SCORE_W-1:0] confidence;
    logic [CHAR_COUNT_W-1:0]   char_count;
    logic                      last;
  } result_item_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_SUM
  } state_t;

endpackage

/* rtl/ctcgd_stream_if.sv */
// Valid/ready stream channel carrying one item per handshake.
interface ctcgd_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ctcgd_divider.sv */
// Iterative signed divider: one quotient bit a cycle, truncates toward zero.
module ctcgd_divider
  import ctcgd_pkg::*;
#(
  parameter int SUM_W = 24,
  parameter int CNT_W = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output div_status_t             status,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic              neg;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;

  // Trial subtraction of the shifted remainder
  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitude, then shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
      neg <= dividend[SUM_W-1];
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  assign quotient    = neg ? SUM_W'(-$signed(quo)) : $signed(quo);
  assign status.busy = busy;
  assign status.done = done;

endmodule

/* rtl/ctc_greedy_decoder_core.sv */
// Greedy CTC decoder: row argmax, repeat/blank collapse and mean confidence.
//
//   channel   dir  handshake          payload
//   scores    in   valid/ready        score (Q3.12), seq_end
//   results   out  valid/ready        kind, char_idx, is_space, confidence,
//                                     char_count, last
//   cfg       in   cfg_wr_en          cfg_index, cfg_wr_data (no read-back)
//
// One score is taken per cycle while running and the result register is free;
// a row's argmax closes on its last score. On seq_end the mean goes through the
// bit-serial divider; no score is taken until the summary is loaded. Reset is
// synchronous and clears the sequence state, all but summary_count.
// A stalled result register holds the next score back until it is taken.
`include "ctc_greedy_decoder_core_assert.svh"

module ctc_greedy_decoder_core
  import ctcgd_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  ctcgd_stream_if.sink           scores,
  ctcgd_stream_if.source         results,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  localparam int POS_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
  localparam int CMP_W = ((POS_W > DICT_W) ? POS_W : DICT_W) + 2;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam int SUM_W = $clog2(MAX_STEPS) + SCORE_W;

  // Configuration registers
  logic [CLASS_CNT_W-1:0] num_classes;
  logic [DICT_W-1:0]      dict_size;

  // Sequence state
  logic [POS_W-1:0]          class_position;
  logic signed [SCORE_W-1:0] row_best_score;
  logic [POS_W-1:0]          row_best_index;
  logic [POS_W-1:0]          previous_best_index;
  logic                      previous_valid;
  logic signed [SUM_W-1:0]   conf_accum;
  logic [CNT_W-1:0]          emitted_count;
  logic [CNT_W-1:0]          summary_count;

  state_t state;
  state_t state_next;

  result_item_t res;
  logic         res_valid;

  score_item_t               item;
  logic                      accept;
  logic                      out_free;
  logic                      load_char;
  logic                      load_sum;
  logic                      start_div;

  logic [CMP_W-1:0]          cc_raw;
  logic [CMP_W-1:0]          cc_eff;
  logic [CMP_W-1:0]          pos_ext;
  logic [CMP_W-1:0]          best_ext;
  logic [CMP_W-1:0]          ci;
  logic [CMP_W-1:0]          dict_ext;
  logic                      take_new;
  logic signed [SCORE_W-1:0] cur_best_score;
  logic [POS_W-1:0]          cur_best_index;
  logic                      row_close;
  logic                      fresh;
  logic                      is_char;
  logic                      is_sp;
  logic                      emit;
  logic                      counted;
  logic signed [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]          count_next;

  div_status_t             div_status;
  logic signed [SUM_W-1:0] div_quotient;

  assign item     = scores.data;
  assign out_free = !res_valid || results.ready;
  assign accept   = scores.valid && scores.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= NUM_CLASSES_RST;
      dict_size   <= DICT_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_CLASSES: num_classes <= cfg_wr_data[CLASS_CNT_W-1:0];
        CFG_DICT_SIZE:   dict_size   <= cfg_wr_data[DICT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective class count, clamped to [2, MAX_CLASSES]
  always_comb begin
    cc_raw = CMP_W'(num_classes);
    if (cc_raw < CMP_W'(2)) begin
      cc_eff = CMP_W'(2);
    end else if (cc_raw > CMP_W'(MAX_CLASSES)) begin
      cc_eff = CMP_W'(MAX_CLASSES);
    end else begin
      cc_eff = cc_raw;
    end
  end

  // Running argmax; the first index wins a tie
  assign take_new       = (class_position == '0) || (item.score > row_best_score);
  assign cur_best_score = take_new ? item.score : row_best_score;
  assign cur_best_index = take_new ? class_position : row_best_index;

  // Row close and emission decision
  assign pos_ext   = CMP_W'(class_position);
  assign row_close = (pos_ext + CMP_W'(1) >= cc_eff) || item.seq_end;
  assign best_ext  = CMP_W'(cur_best_index);
  assign ci        = best_ext - CMP_W'(1);
  assign dict_ext  = CMP_W'(dict_size);
  assign fresh     = (cur_best_index != '0) &&
                     !(previous_valid && (cur_best_index == previous_best_index));
  assign is_char   = ci < dict_ext;
  assign is_sp     = !is_char && (ci == dict_ext) && (cc_eff == dict_ext + CMP_W'(2));
  assign emit      = row_close && fresh && (is_char || is_sp);
  assign counted   = emit && (emitted_count < CNT_W'(MAX_STEPS));

  assign sum_next   = counted ? conf_accum + SUM_W'(cur_best_score) : conf_accum;
  assign count_next = counted ? emitted_count + CNT_W'(1) : emitted_count;

  // Sequencer: next state and strobes
  always_comb begin
    state_next    = state;
    scores.ready  = 1'b0;
    load_char     = 1'b0;
    load_sum      = 1'b0;
    start_div     = 1'b0;
    case (state)
      ST_RUN: begin
        scores.ready = out_free;
        if (scores.valid && out_free) begin
          load_char = emit;
          if (item.seq_end) begin
            start_div  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          load_sum   = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Sequence state update on each accepted score
  always_ff @(posedge clk) begin
    if (rst) begin
      class_position      <= '0;
      row_best_score      <= '0;
      row_best_index      <= '0;
      previous_best_index <= '0;
      previous_valid      <= 1'b0;
      conf_accum          <= '0;
      emitted_count       <= '0;
    end else if (accept) begin
      if (item.seq_end) begin
        class_position      <= '0;
        row_best_score      <= '0;
        row_best_index      <= '0;
        previous_best_index <= '0;
        previous_valid      <= 1'b0;
        conf_accum          <= '0;
        emitted_count       <= '0;
      end else begin
        row_best_score <= cur_best_score;
        row_best_index <= cur_best_index;
        conf_accum     <= sum_next;
        emitted_count  <= count_next;
        if (row_close) begin
          class_position      <= '0;
          previous_best_index <= cur_best_index;
          previous_valid      <= 1'b1;
        end else begin
          class_position <= class_position + 1'b1;
        end
      end
    end
  end

  // Count for the pending summary
  always_ff @(posedge clk) begin
    if (start_div) begin
      summary_count <= count_next;
    end
  end

  ctcgd_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_div),
    .dividend (sum_next),
    .divisor  (count_next),
    .status   (div_status),
    .quotient (div_quotient)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_char || load_sum) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_char) begin
      res.kind       <= KIND_CHAR;
      res.char_idx   <= CHAR_INDEX_W'(ci);
      res.is_space   <= is_sp;
      res.confidence <= '0;
      res.char_count <= '0;
      res.last       <= 1'b0;
    end else if (load_sum) begin
      res.kind       <= KIND_SUMMARY;
      res.char_idx   <= '0;
      res.is_space   <= 1'b0;
      res.confidence <= (summary_count == '0) ? '0 : SCORE_W'(div_quotient);
      res.char_count <= CHAR_COUNT_W'(summary_count);
      res.last       <= 1'b1;
    end
  end

  assign results.valid = res_valid;
  assign results.data  = res;

  // Checks
  `CTCGD_ASSERT_IMP(a_no_take_busy, clk, rst, state != ST_RUN, !scores.ready)
  `CTCGD_ASSERT_NXT(a_end_starts_div, clk, rst, accept && item.seq_end, state == ST_DIV)
  `CTCGD_ASSERT_IMP(a_done_in_div, clk, rst, div_status.done, state == ST_DIV)
  `CTCGD_ASSERT_IMP(a_summary_last, clk, rst, res_valid && (res.kind == KIND_SUMMARY),
                    res.last && (res.char_idx == '0))

endmodule

/* sim/testbench.sv */
// Testbench for the greedy CTC decoder: directed corners, long and wide sequences, random rows.
module testbench;
  import ctcgd_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_SCORES = 640;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  ctcgd_stream_if #(.item_t(score_item_t))  score_ch ();
  ctcgd_stream_if #(.item_t(result_item_t)) result_ch ();

  ctc_greedy_decoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .scores      (score_ch),
    .results     (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoded tokens still awaited from the block, oldest first
  result_item_t decoded_tokens[$];

  int fail_count  = 0;
  int scores_sent = 0;
  int gap_odds    = 0;
  int stall_odds  = 0;
  int hold_len    = 0;
  int cycle_count = 0;

  // Decoder shadow: register copies and per-sequence state
  int cfg_classes;
  int cfg_dict;
  int row_pos;
  int row_top;
  int row_top_idx;
  int prior_idx;
  bit prior_seen;
  int conf_sum;
  int char_total;

  function automatic int effective_classes(input int classes);
    if (classes < 2) return 2;
    if (classes > MAX_CLASSES_DEF) return MAX_CLASSES_DEF;
    return classes;
  endfunction

  function automatic void clear_decode_state();
    row_pos     = 0;
    row_top     = 0;
    row_top_idx = 0;
    prior_idx   = 0;
    prior_seen  = 1'b0;
    conf_sum    = 0;
    char_total  = 0;
  endfunction

  // One accepted score: update the argmax, collapse repeats and blanks, queue tokens
  function automatic void greedy_decode_step(input score_item_t it);
    int s;
    int width;
    int ci;
    int mean;
    bit emit;
    bit space;
    result_item_t r;
    s = it.score;
    width = effective_classes(cfg_classes);
    if (row_pos == 0 || s > row_top) begin
      row_top     = s;
      row_top_idx = row_pos;
    end
    if (row_pos + 1 >= width || it.seq_end) begin
      if (row_top_idx != 0 && !(prior_seen && row_top_idx == prior_idx)) begin
        ci    = row_top_idx - 1;
        emit  = ci < cfg_dict;
        space = 1'b0;
        if (!emit && ci == cfg_dict && width == cfg_dict + 2) begin
          emit  = 1'b1;
          space = 1'b1;
        end
        if (emit) begin
          r            = '0;
          r.kind       = KIND_CHAR;
          r.char_idx   = ci[CHAR_INDEX_W-1:0];
          r.is_space   = space;
          decoded_tokens.insert(decoded_tokens.size(), r);
          // only the first MAX_STEPS characters count towards the mean
          if (char_total < MAX_STEPS_DEF) begin
            conf_sum   += row_top;
            char_total += 1;
          end
        end
      end
      prior_idx  = row_top_idx;
      prior_seen = 1'b1;
      row_pos    = 0;
    end else begin
      row_pos += 1;
    end
    if (it.seq_end) begin
      mean         = (char_total > 0) ? conf_sum / char_total : 0;
      r            = '0;
      r.kind       = KIND_SUMMARY;
      r.confidence = mean[SCORE_W-1:0];
      r.char_count = char_total[CHAR_COUNT_W-1:0];
      r.last       = 1'b1;
      decoded_tokens.insert(decoded_tokens.size(), r);
      clear_decode_state();
    end
  endfunction

  function automatic int idle_odds();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 4;
      default: return 12;
    endcase
  endfunction

  // Offer one score item, with an occasional idle burst first
  task automatic push_score(input logic signed [SCORE_W-1:0] s, input logic e);
    score_item_t it;
    if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      score_ch.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    it.score   = s;
    it.seq_end = e;
    score_ch.valid <= 1'b1;
    score_ch.data  <= it;
    do @(posedge clk); while (score_ch.ready !== 1'b1);
    greedy_decode_step(it);
    scores_sent++;
  endtask

  task automatic send_scores(input int vals[$], input bit end_seq);
    int v;
    foreach (vals[i]) begin
      v = vals[i];
      push_score(v[SCORE_W-1:0], end_seq && i == vals.size() - 1);
    end
  endtask

  // Row of cut scores whose maximum sits at winner unless noisy; later equal scores test the tie rule
  task automatic send_row(input int cut, input int winner, input bit noisy, input bit end_seq);
    int top;
    int v;
    if ($urandom_range(3, 0) == 0)
      top = int'($urandom_range(65534, 0)) - 32767;
    else
      top = int'($urandom_range(32767, 0));
    for (int p = 0; p < cut; p++) begin
      if (noisy)
        v = int'($urandom_range(65535, 0)) - 32768;
      else if (p == winner)
        v = top;
      else if (p > winner && $urandom_range(7, 0) == 0)
        v = top;
      else
        v = int'($urandom_range(top + 32767, 0)) - 32768;
      push_score(v[SCORE_W-1:0], end_seq && p == cut - 1);
    end
  endtask

  // Drop valid and wait until every awaited token is in, then let the pipeline settle
  task automatic wait_drained();
    score_ch.valid <= 1'b0;
    while (decoded_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int classes, input int dict);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_NUM_CLASSES;
    cfg_wr_data <= classes[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index   <= CFG_DICT_SIZE;
    cfg_wr_data <= {1'b0, dict[DICT_W-1:0]};
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_classes = classes & 'h3FFF;
    cfg_dict    = dict & 'h1FFF;
  endtask

  task automatic test_directed_corners();
    int row[$];
    gap_odds   = 0;
    stall_odds = 0;
    // reset setting: sequence of one blank score, empty summary
    row = '{-32768};
    send_scores(row, 1'b1);
    // score extremes, equal later score keeps the lower index, row cut by sequence end
    row = '{-32768, 32767, 32767, 0};
    send_scores(row, 1'b1);
    // class count below range acts as two; a blank splits repeats; negative mean truncates
    write_config(0, 1);
    row = '{-32768, -5, 5, 5, -32768, -2, -1, 0, 3, 3};
    send_scores(row, 1'b1);
    // extra space class when class count is dictionary size plus two
    write_config(3, 1);
    row = '{0, 0, 100, 0, 200, 0};
    send_scores(row, 1'b1);
    // indices past the dictionary emit nothing, then a class count write mid-row
    write_config(4, 1);
    row = '{0, 0, 0, 50, -9, 40};
    send_scores(row, 1'b0);
    write_config(2, 1);
    row = '{10};
    send_scores(row, 1'b1);
  endtask

  // Wide class counts, rows cut by sequence end, with the register above its range
  task automatic test_widest_row();
    gap_odds   = idle_odds();
    stall_odds = idle_odds();
    write_config(16383, 8190);
    send_row(120, 119, 1'b0, 1'b1);
    write_config(MAX_CLASSES_DEF, 8191);
    send_row(100, $urandom_range(99, 1), 1'b0, 1'b1);
  endtask

  // More characters than the count can hold in one sequence
  task automatic test_char_overflow();
    gap_odds   = idle_odds();
    stall_odds = idle_odds();
    write_config(3, 2);
    for (int r = 0; r < 260; r++)
      send_row(3, 1 + r % 2, 1'b0, r == 259);
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_result_backpressure();
    write_config(2, 1);
    gap_odds   = 0;
    stall_odds = 0;
    hold_len   = 400;
    for (int r = 0; r < 40; r++)
      send_row(2, r % 2, 1'b0, r == 39);
  endtask

  task automatic test_random_sequences();
    int first;
    int cc;
    int ds;
    int width;
    int rows;
    int winner;
    int prev;
    int cut;
    bit last_row;
    bit noisy;
    first = scores_sent;
    while (scores_sent - first < RANDOM_SCORES) begin
      case ($urandom_range(4, 0))
        0: begin
          cc = $urandom_range(1, 0);
          ds = $urandom_range(2, 1);
        end
        1: begin
          cc = $urandom_range(24, 3);
          ds = cc - 2;
        end
        2: begin
          cc = $urandom_range(24, 2);
          ds = $urandom_range(cc, 1);
        end
        3: begin
          cc = $urandom_range(24, 2);
          ds = ($urandom_range(1, 0) != 0) ? 8191 : 1;
        end
        default: begin
          cc = $urandom_range(24, 2);
          ds = $urandom_range(8191, 1);
        end
      endcase
      write_config(cc, ds);
      width = effective_classes(cc);
      // no idling towards the end of the run
      if (scores_sent - first > RANDOM_SCORES - 300) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = idle_odds();
        stall_odds = idle_odds();
      end
      repeat ($urandom_range(4, 1)) begin
        rows = $urandom_range(12, 1);
        prev = 0;
        for (int r = 0; r < rows; r++) begin
          last_row = (r == rows - 1);
          case ($urandom_range(7, 0))
            0, 1:    winner = 0;
            2:       winner = prev;
            3:       winner = width - 1;
            default: winner = $urandom_range(width - 1, 0);
          endcase
          cut   = (last_row && $urandom_range(3, 0) == 0) ? $urandom_range(width, 1) : width;
          noisy = ($urandom_range(9, 0) == 0);
          send_row(cut, winner, noisy, last_row);
          prev = winner;
        end
      end
    end
  endtask

  // Result receiver: long hold-offs on request, random stalls otherwise
  initial begin : result_sink
    int span;
    forever begin
      if (hold_len > 0) begin
        span     = hold_len;
        hold_len = 0;
        result_ch.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest awaited token
  always @(posedge clk) begin : result_check
    result_item_t want;
    result_item_t got;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got = result_ch.data;
      if (decoded_tokens.size() == 0) begin
        $error("result with nothing awaited: kind %0d char_idx %0d", got.kind,
               got.char_idx);
        fail_count++;
      end else begin
        want = decoded_tokens.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("char_idx", want.char_idx, got.char_idx);
        check_field("is_space", want.is_space, got.is_space);
        check_field("confidence", want.confidence, got.confidence);
        check_field("char_count", want.char_count, got.char_count);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst            <= 1'b1;
    score_ch.valid <= 1'b0;
    score_ch.data  <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_NUM_CLASSES;
    cfg_wr_data    <= '0;
    cfg_classes = int'(NUM_CLASSES_RST);
    cfg_dict    = int'(DICT_SIZE_RST);
    clear_decode_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_widest_row();
    test_char_overflow();
    test_result_backpressure();
    test_random_sequences();
    wait_drained();

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
